FILE: rtl/assert_macros.svh
// assertion macros used by the tokenizer top level rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/irkt_pkg.sv
// shared types, constants and keyword table for the ir keyword tokenizer
// no dependencies
package irkt_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 7;
    localparam int VALUE_W = 31;
    localparam int POS_W = 5;

    localparam int KEYWORD_COUNT_DEF = 75;
    localparam int MAX_KEYWORD_LENGTH_DEF = 16;

    localparam int KW_TABLE_SIZE = 75;
    localparam int KW_TEXT_BYTES = 16;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_ERROR = 7'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCK_LABEL = 7'd9;
    localparam logic [KIND_W-1:0] KIND_IDENTIFIER = 7'd35;
    localparam logic [KIND_W-1:0] KIND_INTEGER_TYPE = 7'd37;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 7'd65;

    typedef enum logic [1:0] {
        INT_NONE,
        INT_I_SEEN,
        INT_DIGITS
    } int_state_t;

    typedef logic [8*KW_TEXT_BYTES-1:0] kw_text_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        kw_text_t          text;
    } kw_entry_t;

    // one byte beat as seen by the keyword matcher
    typedef struct packed {
        logic              advance;
        logic              last;
        logic [CHAR_W-1:0] code;
        logic [POS_W-1:0]  pos;
    } irkt_step_t;

    // text is right-justified, first character in the highest used byte
    function automatic kw_entry_t kw_entry(input int k);
        kw_entry_t e;
        case (k)
            0:  e = '{7'd1,  "add"};
            1:  e = '{7'd2,  "aggr"};
            2:  e = '{7'd3,  "align"};
            3:  e = '{7'd4,  "alloca"};
            4:  e = '{7'd5,  "and"};
            5:  e = '{7'd6,  "ashr"};
            6:  e = '{7'd7,  "bigendian"};
            7:  e = '{7'd8,  "bitcast"};
            8:  e = '{7'd10, "br"};
            9:  e = '{7'd11, "call"};
            10: e = '{7'd12, "]"};
            11: e = '{7'd13, "}"};
            12: e = '{7'd14, ")"};
            13: e = '{7'd15, ","};
            14: e = '{7'd16, "declare"};
            15: e = '{7'd17, "define"};
            16: e = '{7'd18, "..."};
            17: e = '{7'd19, "double"};
            18: e = '{7'd20, "="};
            19: e = '{7'd21, "fadd"};
            20: e = '{7'd22, "false"};
            21: e = '{7'd23, "fcmp"};
            22: e = '{7'd24, "fdiv"};
            23: e = '{7'd25, "float"};
            24: e = '{7'd26, "fmul"};
            25: e = '{7'd27, "fpext"};
            26: e = '{7'd28, "fptoui"};
            27: e = '{7'd29, "free"};
            28: e = '{7'd30, "frem"};
            29: e = '{7'd31, "fsub"};
            30: e = '{7'd32, "getelementptr"};
            31: e = '{7'd33, "global"};
            32: e = '{7'd34, "icmp"};
            33: e = '{7'd36, "inbounds"};
            34: e = '{7'd38, "inttoptr"};
            35: e = '{7'd39, "littleendian"};
            36: e = '{7'd40, "label"};
            37: e = '{7'd41, "load"};
            38: e = '{7'd42, "lshr"};
            39: e = '{7'd43, "malloc"};
            40: e = '{7'd44, "mul"};
            41: e = '{7'd45, "null"};
            42: e = '{7'd46, "nsw"};
            43: e = '{7'd47, "{"};
            44: e = '{7'd48, "["};
            45: e = '{7'd49, "("};
            46: e = '{7'd50, "or"};
            47: e = '{7'd51, "phi"};
            48: e = '{7'd52, "*"};
            49: e = '{7'd53, "ptrtoint"};
            50: e = '{7'd54, "ret"};
            51: e = '{7'd55, "sdiv"};
            52: e = '{7'd56, "select"};
            53: e = '{7'd57, "sext"};
            54: e = '{7'd58, "sle"};
            55: e = '{7'd59, "slt"};
            56: e = '{7'd60, "shl"};
            57: e = '{7'd61, "srem"};
            58: e = '{7'd62, "stack"};
            59: e = '{7'd63, "store"};
            60: e = '{7'd64, "sub"};
            61: e = '{7'd66, "to"};
            62: e = '{7'd67, "trunc"};
            63: e = '{7'd68, "true"};
            64: e = '{7'd69, "typ"};
            65: e = '{7'd70, "udiv"};
            66: e = '{7'd71, "undef"};
            67: e = '{7'd72, "unreachable"};
            68: e = '{7'd73, "urem"};
            69: e = '{7'd74, "val"};
            70: e = '{7'd75, "void"};
            71: e = '{7'd76, "x"};
            72: e = '{7'd77, "xor"};
            73: e = '{7'd78, "zeroinitializer"};
            74: e = '{7'd79, "zext"};
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic int kw_len(input kw_text_t t);
        int n;
        n = 0;
        for (int i = 0; i < KW_TEXT_BYTES; i++)
        begin
            if (t[8*i +: 8] != 8'h00)
                n = i + 1;
        end
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input kw_text_t t, input int len,
                                                 input int j);
        return t[8*(len-1-j) +: 8];
    endfunction

endpackage

FILE: rtl/irkt_kw_match.sv
// keyword matcher: one live bit per keyword, pruned by each byte beat and set again on a word's last beat
// depends on irkt_pkg
module irkt_kw_match
    import irkt_pkg::*;
#(
    parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF,
    parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  irkt_step_t        step,
    output logic [KIND_W-1:0] match_kind
);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_KEYWORD_LENGTH);

    logic [KEYWORD_COUNT-1:0] alive_reg;
    logic [KEYWORD_COUNT-1:0] alive_next;
    logic [KEYWORD_COUNT-1:0] complete;
    logic [KIND_W-1:0]        kind_term [KEYWORD_COUNT];
    logic                     pos_ok;

    assign pos_ok = step.pos < POS_LIMIT;

    for (genvar k = 0; k < KEYWORD_COUNT; k++)
    begin : g_kw
        if (k < KW_TABLE_SIZE)
        begin : g_entry
            localparam kw_entry_t ENTRY = kw_entry(k);
            localparam int LEN = kw_len(ENTRY.text);

            logic [KW_TEXT_BYTES-1:0] char_hit;

            for (genvar j = 0; j < KW_TEXT_BYTES; j++)
            begin : g_pos
                if (j < LEN)
                begin : g_cmp
                    localparam logic [CHAR_W-1:0] CH = kw_char(ENTRY.text, LEN, j);
                    assign char_hit[j] = (step.pos == POS_W'(j)) && (step.code == CH);
                end
                else
                begin : g_none
                    assign char_hit[j] = 1'b0;
                end
            end

            assign alive_next[k] = alive_reg[k] && pos_ok && (|char_hit);
            assign complete[k]   = alive_next[k] && (step.pos == POS_W'(LEN - 1));
            assign kind_term[k]  = complete[k] ? ENTRY.kind : KIND_ERROR;
        end
        else
        begin : g_unused
            assign alive_next[k] = 1'b0;
            assign complete[k]   = 1'b0;
            assign kind_term[k]  = KIND_ERROR;
        end
    end

    // keywords are distinct, so at most one completes
    always_comb
    begin
        match_kind = KIND_ERROR;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            match_kind = match_kind | kind_term[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '1;
        end
        else if (step.advance)
        begin
            alive_reg <= step.last ? '1 : alive_next;
        end
    end

endmodule

FILE: rtl/ir_keyword_tokenizer.sv
// top level of the ir keyword tokenizer: class flags, token decision, result register
// depends on irkt_pkg, irkt_kw_match and assert_macros.svh
//
// One byte of a word is taken per cycle and the token for a word appears in the
// token register the cycle after its last byte is taken, so a stream of words
// runs at one byte per clock. The byte input stalls only while a finished token
// is held and the token side is stalling. Each beat compares the byte with every
// keyword's character at the current position and prunes the live mask, so the
// path per cycle is one byte compare per keyword, an or of the completing kinds
// and the number accumulate (times ten plus digit, with saturation).
`include "assert_macros.svh"

module ir_keyword_tokenizer
    import irkt_pkg::*;
#(
    parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF,
    parameter int MAX_KEYWORD_LENGTH = MAX_KEYWORD_LENGTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               word_end,
    output logic               token_valid,
    input  logic               token_stall,
    output logic [KIND_W-1:0]  token_kind,
    output logic [VALUE_W-1:0] token_value
);

    logic                accept;
    irkt_step_t          step;
    logic [KIND_W-1:0]   match_kind;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CHAR_W-1:0]   first_reg, first_next;
    logic                all_digits_reg, all_digits_next;
    logic                all_letters_reg, all_letters_next;
    int_state_t          int_reg, int_next;
    logic [VALUE_W-1:0]  number_reg, number_next;

    logic                digit;
    logic                letter;
    logic [VALUE_W+3:0]  number_sum;

    logic                token_valid_reg;
    logic [KIND_W-1:0]   token_kind_reg, token_kind_next;
    logic [VALUE_W-1:0]  token_value_reg, token_value_next;

    assign item_stall = token_valid_reg && token_stall;
    assign accept     = item_valid && !item_stall;

    assign step.advance = accept;
    assign step.last    = word_end;
    assign step.code    = char_code;
    assign step.pos     = pos_reg;

    irkt_kw_match #(
        .KEYWORD_COUNT      (KEYWORD_COUNT),
        .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH)
    ) u_kw_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .match_kind (match_kind)
    );

    always_comb
    begin
        digit  = (char_code >= "0") && (char_code <= "9");
        letter = ((char_code >= "a") && (char_code <= "z")) ||
                 ((char_code >= "A") && (char_code <= "Z"));

        pos_next   = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        first_next = (pos_reg == '0) ? char_code : first_reg;

        if (pos_reg == '0)
            int_next = (char_code == "i") ? INT_I_SEEN : INT_NONE;
        else
            int_next = ((int_reg != INT_NONE) && digit) ? INT_DIGITS : INT_NONE;

        all_digits_next  = all_digits_reg && digit;
        all_letters_next = all_letters_reg && letter;

        // value times ten plus digit, saturating
        number_sum = {1'b0, number_reg, 3'b000} + {3'b000, number_reg, 1'b0}
                   + {(VALUE_W + 0)'(0), char_code[3:0]};
        if (!digit)
            number_next = number_reg;
        else if (number_sum > {4'b0000, VALUE_MAX})
            number_next = VALUE_MAX;
        else
            number_next = number_sum[VALUE_W-1:0];

        token_value_next = '0;
        if (match_kind != KIND_ERROR)
            token_kind_next = match_kind;
        else if ((first_next == "%") || (first_next == "@") || (first_next == "#"))
            token_kind_next = KIND_IDENTIFIER;
        else if (all_digits_next)
        begin
            token_kind_next  = KIND_NUMBER;
            token_value_next = number_next;
        end
        else if (int_next == INT_DIGITS)
        begin
            token_kind_next  = KIND_INTEGER_TYPE;
            token_value_next = number_next;
        end
        else if (all_letters_reg && (char_code == ":"))
            token_kind_next = KIND_BLOCK_LABEL;
        else
            token_kind_next = KIND_ERROR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            first_reg       <= '0;
            all_digits_reg  <= 1'b1;
            all_letters_reg <= 1'b1;
            int_reg         <= INT_NONE;
            number_reg      <= '0;
        end
        else if (accept)
        begin
            if (word_end)
            begin
                pos_reg         <= '0;
                first_reg       <= '0;
                all_digits_reg  <= 1'b1;
                all_letters_reg <= 1'b1;
                int_reg         <= INT_NONE;
                number_reg      <= '0;
            end
            else
            begin
                pos_reg         <= pos_next;
                first_reg       <= first_next;
                all_digits_reg  <= all_digits_next;
                all_letters_reg <= all_letters_next;
                int_reg         <= int_next;
                number_reg      <= number_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_valid_reg <= 1'b0;
        end
        else if (accept && word_end)
        begin
            token_valid_reg <= 1'b1;
        end
        else if (!token_stall)
        begin
            token_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && word_end)
        begin
            token_kind_reg  <= token_kind_next;
            token_value_reg <= token_value_next;
        end
    end

    assign token_valid = token_valid_reg;
    assign token_kind  = token_kind_reg;
    assign token_value = token_value_reg;

    `ASSERT_NEXT(a_token_after_end, accept && word_end, token_valid_reg,
                 "no token after last beat")
    `ASSERT_NEXT(a_word_state_cleared, accept && word_end,
                 (pos_reg == '0) && all_digits_reg && all_letters_reg,
                 "word state not cleared")
    `ASSERT_NEXT(a_pos_advances, accept && !word_end, pos_reg != '0,
                 "position did not advance")
    `ASSERT_IMPLIES(a_value_only_numeric,
                    token_valid_reg && (token_kind_reg != KIND_NUMBER)
                        && (token_kind_reg != KIND_INTEGER_TYPE),
                    token_value_reg == '0, "value on non-numeric token")

endmodule

FILE: verif/tb.sv
// testbench for ir_keyword_tokenizer: words of keywords, identifiers, numbers, integer types,
// labels and noise go in one byte per beat, and each token is checked against a local predictor
// depends on irkt_pkg and the tokenizer rtl

class token_scoreboard;
    string kw_text[75];
    bit [6:0] kw_kind[75];
    bit alive[75];
    int unsigned char_pos;
    bit [7:0] lead_char;
    bit digits_only;
    bit letters_only;
    irkt_pkg::int_state_t int_state;
    int unsigned num_value;
    bit [6:0] kind_q[$];
    bit [30:0] value_q[$];
    int errors;

    function new();
        kw_text = '{"add", "aggr", "align", "alloca", "and", "ashr", "bigendian", "bitcast",
                    "br", "call", "]", "}", ")", ",", "declare", "define", "...", "double",
                    "=", "fadd", "false", "fcmp", "fdiv", "float", "fmul", "fpext", "fptoui",
                    "free", "frem", "fsub", "getelementptr", "global", "icmp", "inbounds",
                    "inttoptr", "littleendian", "label", "load", "lshr", "malloc", "mul",
                    "null", "nsw", "{", "[", "(", "or", "phi", "*", "ptrtoint", "ret", "sdiv",
                    "select", "sext", "sle", "slt", "shl", "srem", "stack", "store", "sub",
                    "to", "trunc", "true", "typ", "udiv", "undef", "unreachable", "urem",
                    "val", "void", "x", "xor", "zeroinitializer", "zext"};
        kw_kind = '{1, 2, 3, 4, 5, 6, 7, 8, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21,
                    22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33, 34, 36, 38, 39, 40, 41,
                    42, 43, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 55, 56, 57, 58, 59,
                    60, 61, 62, 63, 64, 66, 67, 68, 69, 70, 71, 72, 73, 74, 75, 76, 77, 78,
                    79};
        errors = 0;
        clear_word();
    endfunction

    function void clear_word();
        foreach (alive[k])
            alive[k] = 1'b1;
        char_pos = 0;
        lead_char = 8'h00;
        digits_only = 1'b1;
        letters_only = 1'b1;
        int_state = irkt_pkg::INT_NONE;
        num_value = 0;
    endfunction

    task report(string field, longint got, longint want);
        $display("tb: %s mismatch, got %0d expected %0d", field, got, want);
        errors++;
    endtask

    function int pending();
        return kind_q.size();
    endfunction

    function void note_byte(bit [7:0] c, bit last);
        int unsigned p;
        int unsigned d;
        bit digit;
        bit letter;
        bit label_end;
        bit [6:0] kind;
        bit [30:0] value;
        p = char_pos;
        digit = c >= "0" && c <= "9";
        letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        label_end = letters_only && c == ":";
        kind = irkt_pkg::KIND_ERROR;
        value = '0;
        foreach (alive[k])
            alive[k] = alive[k] && p < 16 && p < kw_text[k].len() && kw_text[k][p] == c;
        if (p == 0)
        begin
            lead_char = c;
            int_state = (c == "i") ? irkt_pkg::INT_I_SEEN : irkt_pkg::INT_NONE;
        end
        else
        begin
            int_state = (int_state != irkt_pkg::INT_NONE && digit) ? irkt_pkg::INT_DIGITS
                                                                   : irkt_pkg::INT_NONE;
        end
        digits_only = digits_only && digit;
        letters_only = letters_only && letter;
        if (digit)
        begin
            d = c - "0";
            if (num_value > (irkt_pkg::VALUE_MAX - d) / 10)
                num_value = irkt_pkg::VALUE_MAX;
            else
                num_value = num_value * 10 + d;
        end
        if (char_pos < 31)
            char_pos++;
        if (!last)
            return;
        for (int k = 0; k < 75; k++)
        begin
            if (alive[k] && kw_text[k].len() == p + 1)
            begin
                kind = kw_kind[k];
                break;
            end
        end
        if (kind == irkt_pkg::KIND_ERROR)
        begin
            if (lead_char == "%" || lead_char == "@" || lead_char == "#")
                kind = irkt_pkg::KIND_IDENTIFIER;
            else if (digits_only)
            begin
                kind = irkt_pkg::KIND_NUMBER;
                value = num_value[30:0];
            end
            else if (int_state == irkt_pkg::INT_DIGITS)
            begin
                kind = irkt_pkg::KIND_INTEGER_TYPE;
                value = num_value[30:0];
            end
            else if (label_end)
                kind = irkt_pkg::KIND_BLOCK_LABEL;
        end
        kind_q.push_back(kind);
        value_q.push_back(value);
        clear_word();
    endfunction

    task check_token(bit [6:0] kind, bit [30:0] value);
        bit [6:0] want_kind;
        bit [30:0] want_value;
        if (kind_q.size() == 0)
        begin
            report("token_valid", 1, 0);
            return;
        end
        want_kind = kind_q.pop_front();
        want_value = value_q.pop_front();
        if (kind != want_kind)
            report("token_kind", kind, want_kind);
        if (value != want_value)
            report("token_value", value, want_value);
    endtask
endclass

module tb;
    import irkt_pkg::*;

    typedef bit [7:0] word_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [CHAR_W-1:0] char_code = '0;
    logic word_end = 1'b0;
    logic token_valid;
    logic token_stall = 1'b0;
    logic [KIND_W-1:0] token_kind;
    logic [VALUE_W-1:0] token_value;

    token_scoreboard sb;
    int src_rate = 0;
    int snk_rate = 0;
    int snk_left = 0;
    int byte_count = 0;
    int kw_cursor = 0;

    ir_keyword_tokenizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .char_code(char_code),
        .word_end(word_end),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token_kind(token_kind),
        .token_value(token_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

    // token side stalls in bursts
    always @(negedge clk)
    begin
        if (snk_left > 0)
        begin
            snk_left--;
            token_stall <= 1'b1;
        end
        else if (snk_rate > 0 && $urandom_range(0, 99) < snk_rate)
        begin
            snk_left = $urandom_range(0, 6);
            token_stall <= 1'b1;
        end
        else
            token_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_valid && !token_stall)
                sb.check_token(token_kind, token_value);
            if (item_valid && !item_stall)
                sb.note_byte(char_code, word_end);
        end
    end

    task automatic send_byte(bit [7:0] c, bit last);
        int n;
        if (src_rate > 0 && $urandom_range(0, 99) < src_rate)
        begin
            n = $urandom_range(1, 7);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        char_code <= c;
        word_end <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        byte_count++;
    endtask

    task automatic send_word(word_t w);
        foreach (w[i])
            send_byte(w[i], i == w.size() - 1);
    endtask

    task automatic send_text(string s);
        word_t w;
        for (int i = 0; i < s.len(); i++)
            w.push_back(s[i]);
        send_word(w);
    endtask

    function automatic bit [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'd97 : 8'd65) + 8'($urandom_range(0, 25));
    endfunction

    function automatic bit [7:0] rand_digit();
        return 8'd48 + 8'($urandom_range(0, 9));
    endfunction

    task automatic make_word(output word_t w);
        int sel;
        int n;
        int k;
        string t;
        w = {};
        sel = $urandom_range(0, 99);
        if (sel < 48)
        begin
            if (kw_cursor < 75)
            begin
                k = kw_cursor;
                kw_cursor++;
            end
            else
                k = $urandom_range(0, 74);
            t = sb.kw_text[k];
            for (int i = 0; i < t.len(); i++)
                w.push_back(t[i]);
            // near misses around a keyword
            if (sel >= 40)
            begin
                case ($urandom_range(0, 2))
                    0: if (w.size() > 1) void'(w.pop_back());
                    1: w.push_back(rand_letter());
                    default: w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(0, 255));
                endcase
            end
        end
        else if (sel < 56)
        begin
            case ($urandom_range(0, 2))
                0: w.push_back("%");
                1: w.push_back("@");
                default: w.push_back("#");
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
            repeat (n) w.push_back(8'($urandom_range(0, 255)));
        end
        else if (sel < 66)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            repeat (n) w.push_back(rand_digit());
        end
        else if (sel < 74)
        begin
            w.push_back("i");
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 36) : $urandom_range(0, 4);
            repeat (n) w.push_back(rand_digit());
        end
        else if (sel < 82)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 8);
            repeat (n) w.push_back(rand_letter());
            if ($urandom_range(0, 4) == 0)
                w.push_back(rand_digit());
            w.push_back(":");
            if ($urandom_range(0, 5) == 0)
                w.push_back(rand_letter());
        end
        else if (sel < 91)
        begin
            n = $urandom_range(1, 10);
            repeat (n) w.push_back(8'($urandom_range(33, 126)));
        end
        else
        begin
            n = $urandom_range(1, 40);
            repeat (n) w.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                w.push_back(":");
        end
    endtask

    initial
    begin
        word_t w;
        int words;
        words = 0;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("x");
        send_text(":");
        send_text("0");
        w = {8'hff};
        send_word(w);
        send_text("%");
        send_text("i0");
        send_text("i");
        send_text("abc:");
        send_text("9999999999");

        while (byte_count < 1900)
        begin
            if (words % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: src_rate = 0;
                    1: src_rate = 10;
                    2: src_rate = 30;
                    default: src_rate = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: snk_rate = 0;
                    1: snk_rate = 10;
                    2: snk_rate = 30;
                    default: snk_rate = 60;
                endcase
            end
            // quiet tail
            if (byte_count >= 1650)
            begin
                src_rate = 0;
                snk_rate = 0;
            end
            make_word(w);
            send_word(w);
            words++;
        end
        @(negedge clk);
        item_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/irkt_pkg.sv
rtl/irkt_kw_match.sv
rtl/ir_keyword_tokenizer.sv
verif/tb.sv
